// ----- design/h2r_pkg.sv -----
// h2r_pkg: shared types and constants for the hsv to rgb565 converter
// no dependencies; used by hsv_to_rgb565

package h2r_pkg;

    // 60-degree hue sector, named after the colour at its start
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    // full scale of a unit fraction (1.0) on the saturation and value inputs
    localparam logic [8:0] UNIT_ONE = 9'd256;

    // largest 8-bit channel level
    localparam logic [8:0] CH_MAX = 9'd255;

endpackage

// ----- design/h2r_cdiv.sv -----
// h2r_cdiv: registered unsigned divide by a constant, done as a multiply by
// a rounded-up reciprocal; exact for every input of IN_W bits. no dependencies

module h2r_cdiv #(
    parameter int IN_W  = 16,
    parameter int DIV   = 15,
    parameter int OUT_W = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  num,
    output logic [OUT_W-1:0] quot
);

    // reciprocal with enough guard bits for an exact floor over the input range
    localparam int              SHIFT  = IN_W + $clog2(DIV);
    localparam longint unsigned MULT   = ((64'd1 << SHIFT) + DIV - 1) / DIV;
    localparam int              MW     = $clog2(MULT + 1);
    localparam int              PW     = IN_W + MW;
    localparam logic [MW-1:0]   MULT_C = MW'(MULT);

    logic [PW-1:0]    prod;
    logic [OUT_W-1:0] quot_reg;
    logic [OUT_W-1:0] quot_next;

    // reciprocal multiply and scale
    always_comb
    begin
        prod      = PW'(num) * PW'(MULT_C);
        quot_next = OUT_W'(prod >> SHIFT);
    end

    // quotient register, loads with its pipeline stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ----- design/hsv_to_rgb565.sv -----
// hsv_to_rgb565: pipelined hsv to rgb888 / rgb565 colour converter
// depends on h2r_pkg and h2r_cdiv
//
// usage
//   input channel: hue (signed, 2^-HUE_FRAC_BITS degree units, any turn),
//   saturation and brightness (0..256 = 0..1.0, larger values read as 1.0),
//   with in_valid / in_ready. a transaction is one colour.
//   output channel: red8, green8, blue8 and packed565 with out_valid /
//   out_ready, one result transaction per input transaction, in order.
//   pipeline: 7 register stages (hue offset, sector divide and s*v
//   multiply, remainder and chroma, sector and weight, chroma*weight
//   multiply, divide by the sector span, channel scaling and packing).
//   throughput: one transaction per cycle while out_ready is high; each stage
//   owns a valid bit, and each multiply and divide lies within its stage.
//   stall: when out_ready is low, results hold in the output register and
//   earlier stages keep filling their empty slots; in_ready drops only once
//   every stage holds a colour. nothing is dropped or repeated.
//   reset: rst_n clears all valid bits, so the pipe starts empty; data
//   registers are not reset.

module hsv_to_rgb565 #(
    parameter int HUE_FRAC_BITS      = 4,
    parameter int INTERNAL_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] hue,
    input  logic        [8:0]  saturation,
    input  logic        [8:0]  brightness,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [7:0]  red8,
    output logic        [7:0]  green8,
    output logic        [7:0]  blue8,
    output logic        [15:0] packed565
);

    // hue geometry: span of one sector and of a full turn
    localparam int SPAN   = 60 << HUE_FRAC_BITS;
    localparam int TURN   = 360 << HUE_FRAC_BITS;
    // smallest whole number of turns that makes every hue non-negative
    localparam int OFF    = ((32768 + TURN - 1) / TURN) * TURN;
    localparam int UMAX   = OFF + 32767;
    localparam int UW     = $clog2(UMAX + 1);
    // span = 15 * 2^SH
    localparam int SH     = HUE_FRAC_BITS + 2;
    localparam int N1W    = UW - SH;
    localparam int QW     = $clog2(UMAX / SPAN + 1);
    localparam int RW     = SH + 4;
    localparam int KW     = SH + 4;
    // internal fixed point: chroma and levels are at most 1.0
    localparam int F      = INTERNAL_FRAC_BITS;
    localparam int CW     = F + 1;
    localparam int CKW    = CW + KW;
    localparam int XNW    = CKW - SH;

    // per-stage valid bits and load enables
    logic [7:1] vld_reg;
    logic [7:1] vld_next;
    logic [8:1] ld;

    // stage 1
    logic [UW-1:0]  u1_reg,   u1_next;
    logic [8:0]     sat1_reg, sat1_next;
    logic [8:0]     val1_reg, val1_next;
    logic signed [31:0] hue_sum;
    // stage 2
    logic [QW-1:0]  q2;
    logic [N1W-1:0] n2_reg;
    logic [SH-1:0]  lo2_reg;
    logic [16:0]    p2_reg,   p2_next;
    logic [8:0]     val2_reg;
    // stage 3
    logic [QW-1:0]  q3_reg;
    logic [QW-1:0]  q6_3;
    logic [RW-1:0]  rem3_reg, rem3_next;
    logic [CW-1:0]  c3_reg,   c3_next;
    logic [CW-1:0]  v3_reg,   v3_next;
    logic [N1W-1:0] q2_wide;
    logic [N1W-1:0] r15_wide;
    logic [16+F:0]  pf;
    // stage 4
    h2r_pkg::sector_t sec4_reg, sec4_next;
    logic [KW-1:0]  k4_reg,   k4_next;
    logic [CW-1:0]  c4_reg;
    logic [CW-1:0]  m4_reg,   m4_next;
    logic [QW-1:0]  q6x;
    // stage 5
    logic [CKW-1:0] ck5_reg,  ck5_next;
    h2r_pkg::sector_t sec5_reg;
    logic [CW-1:0]  c5_reg;
    logic [CW-1:0]  m5_reg;
    // stage 6
    logic [CW-1:0]  x6;
    h2r_pkg::sector_t sec6_reg;
    logic [CW-1:0]  c6_reg;
    logic [CW-1:0]  m6_reg;
    // stage 7 (output register)
    logic [7:0]     red_reg,   red_next;
    logic [7:0]     green_reg, green_next;
    logic [7:0]     blue_reg,  blue_next;
    logic [15:0]    pack_reg,  pack_next;
    logic [CW-1:0]  base [3];
    logic [CW-1:0]  lvl  [3];
    logic [CW+7:0]  scl  [3];
    logic [8:0]     chn  [3];
    logic [7:0]     ch8  [3];

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        ld[8] = out_ready;
        for (int i = 7; i >= 1; i--)
        begin
            ld[i] = ~vld_reg[i] | ld[i+1];
        end
        vld_next = vld_reg;
        if (ld[1])
        begin
            vld_next[1] = in_valid;
        end
        for (int i = 2; i <= 7; i++)
        begin
            if (ld[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = ld[1];
    assign out_valid = vld_reg[7];

    // stage 1: make the hue non-negative, clamp the unit fractions
    always_comb
    begin
        hue_sum   = 32'(hue) + OFF;
        u1_next   = hue_sum[UW-1:0];
        sat1_next = (saturation > h2r_pkg::UNIT_ONE) ? h2r_pkg::UNIT_ONE : saturation;
        val1_next = (brightness > h2r_pkg::UNIT_ONE) ? h2r_pkg::UNIT_ONE : brightness;
    end

    // stage 2: hue / span via divide by 15 of the shifted hue, s*v product
    h2r_cdiv #(
        .IN_W  (N1W),
        .DIV   (15),
        .OUT_W (QW)
    ) u_div_sector (
        .clk  (clk),
        .en   (ld[2]),
        .num  (u1_reg[UW-1:SH]),
        .quot (q2)
    );

    assign p2_next = 17'(sat1_reg) * 17'(val1_reg);

    // stage 3: remainder within the sector, chroma and value in fixed point
    h2r_cdiv #(
        .IN_W  (QW),
        .DIV   (6),
        .OUT_W (QW)
    ) u_div_turn (
        .clk  (clk),
        .en   (ld[3]),
        .num  (q2),
        .quot (q6_3)
    );

    always_comb
    begin
        q2_wide   = N1W'(q2);
        r15_wide  = n2_reg - (q2_wide << 4) + q2_wide;
        rem3_next = {r15_wide[3:0], lo2_reg};
        pf        = {p2_reg, F'(0)};
        c3_next   = CW'(pf >> 16);
        v3_next   = CW'(val2_reg) << (F - 8);
    end

    // stage 4: sector within the turn, weight of the secondary term, offset
    always_comb
    begin
        q6x       = q3_reg - (q6_3 << 2) - (q6_3 << 1);
        sec4_next = h2r_pkg::sector_t'(q6x[2:0]);
        if (q6x[0])
        begin
            k4_next = KW'(SPAN) - KW'(rem3_reg);
        end
        else
        begin
            k4_next = KW'(rem3_reg);
        end
        m4_next = v3_reg - c3_reg;
    end

    // stage 5: chroma times weight
    assign ck5_next = CKW'(c4_reg) * CKW'(k4_reg);

    // stage 6: divide by the sector span (shift, then divide by 15)
    h2r_cdiv #(
        .IN_W  (XNW),
        .DIV   (15),
        .OUT_W (CW)
    ) u_div_span (
        .clk  (clk),
        .en   (ld[6]),
        .num  (ck5_reg[CKW-1:SH]),
        .quot (x6)
    );

    // stage 7: channel order by sector, scale by 255, saturate, pack
    always_comb
    begin
        unique case (sec6_reg)
            h2r_pkg::SEC_RED:
            begin
                base[0] = c6_reg; base[1] = x6;     base[2] = '0;
            end
            h2r_pkg::SEC_YELLOW:
            begin
                base[0] = x6;     base[1] = c6_reg; base[2] = '0;
            end
            h2r_pkg::SEC_GREEN:
            begin
                base[0] = '0;     base[1] = c6_reg; base[2] = x6;
            end
            h2r_pkg::SEC_CYAN:
            begin
                base[0] = '0;     base[1] = x6;     base[2] = c6_reg;
            end
            h2r_pkg::SEC_BLUE:
            begin
                base[0] = x6;     base[1] = '0;     base[2] = c6_reg;
            end
            default:
            begin
                base[0] = c6_reg; base[1] = '0;     base[2] = x6;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            lvl[i] = base[i] + m6_reg;
            scl[i] = ((CW+8)'(lvl[i]) << 8) - (CW+8)'(lvl[i]);
            chn[i] = 9'(scl[i] >> F);
            ch8[i] = (chn[i] > h2r_pkg::CH_MAX) ? 8'hFF : chn[i][7:0];
        end
        red_next   = ch8[0];
        green_next = ch8[1];
        blue_next  = ch8[2];
        pack_next  = {ch8[0][7:3], ch8[1][7:2], ch8[2][7:3]};
    end

    // pipeline data registers, each stage loads with its enable
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            u1_reg   <= u1_next;
            sat1_reg <= sat1_next;
            val1_reg <= val1_next;
        end
        if (ld[2])
        begin
            n2_reg   <= u1_reg[UW-1:SH];
            lo2_reg  <= u1_reg[SH-1:0];
            p2_reg   <= p2_next;
            val2_reg <= val1_reg;
        end
        if (ld[3])
        begin
            q3_reg   <= q2;
            rem3_reg <= rem3_next;
            c3_reg   <= c3_next;
            v3_reg   <= v3_next;
        end
        if (ld[4])
        begin
            sec4_reg <= sec4_next;
            k4_reg   <= k4_next;
            c4_reg   <= c3_reg;
            m4_reg   <= m4_next;
        end
        if (ld[5])
        begin
            ck5_reg  <= ck5_next;
            sec5_reg <= sec4_reg;
            c5_reg   <= c4_reg;
            m5_reg   <= m4_reg;
        end
        if (ld[6])
        begin
            sec6_reg <= sec5_reg;
            c6_reg   <= c5_reg;
            m6_reg   <= m5_reg;
        end
        if (ld[7])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            pack_reg  <= pack_next;
        end
    end

    assign red8      = red_reg;
    assign green8    = green_reg;
    assign blue8     = blue_reg;
    assign packed565 = pack_reg;

endmodule
